// ===== design/sample_ring_fifo_with_stats_macros.svh =====
// assertion macros for the sample ring fifo
`ifndef SAMPLE_RING_FIFO_WITH_STATS_MACROS_SVH
`define SAMPLE_RING_FIFO_WITH_STATS_MACROS_SVH

`ifndef SYNTHESIS
`define SRFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SRFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SRFS_ASSERT_SAME(label, ante, cons)
`define SRFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/srfs_pkg.sv =====
package srfs_pkg;

    localparam int STORE_DEPTH  = 1024;
    localparam int SAMPLE_WIDTH = 32;

    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;
    // log2 of the largest power of two not above the store depth
    localparam int CAP_MAX_LOG2 = $clog2(STORE_DEPTH + 1) - 1;

    localparam int OPCODE_W     = 2;
    localparam int SAMPLE_IN_W  = 32;
    localparam int HEAD_W       = 32;
    localparam int QUEUED_W     = 11;
    localparam int OVF_W        = 32;
    localparam int HWM_W        = 11;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int SIZE_LOG2_W  = 4;

    localparam logic [CFG_IDX_W-1:0]   CFG_RING_ENABLED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0]   CFG_RING_SIZE_LOG2 = 1'd1;
    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET    = 4'd10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_PEEK    = 2'd1,
        OP_CONSUME = 2'd2
    } t_opcode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic start;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/srfs_in_if.sv =====
interface srfs_in_if;
    import srfs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [SAMPLE_IN_W-1:0] sample_in;

    modport source (output valid, output opcode, output sample_in, input ready);
    modport sink   (input valid, input opcode, input sample_in, output ready);
endinterface

// ===== design/srfs_out_if.sv =====
interface srfs_out_if;
    import srfs_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [HEAD_W-1:0]   head_sample;
    logic [QUEUED_W-1:0] queued;
    logic [OVF_W-1:0]    overflow_count;
    logic [HWM_W-1:0]    high_water;

    modport source (output valid, output ok, output head_sample, output queued,
                    output overflow_count, output high_water, input ready);
    modport sink   (input valid, input ok, input head_sample, input queued,
                    input overflow_count, input high_water, output ready);
endinterface

// ===== design/sample_ring_fifo_with_stats.sv =====
// sample ring fifo with occupancy statistics
// input channel i_in carries one opcode per transfer: push sample_in, peek the
// head or consume the head; output channel o_out returns exactly one result
// per input transfer with ok, the head sample, queued count, overflow count
// and high-water mark. a push into a full ring is dropped and counted.
// configuration: i_cfg_we with i_cfg_idx 0 (ring enable) or 1 (log2 capacity)
// and i_cfg_wdata; every write clears pointers, overflow count and high water.
// flow: the input transfer and the registered read of the single sample store
// happen at accept, and the result enters the output register at commit once the
// output is free; a new item is taken only after the last one has committed.
// reset: ring disabled, log2 capacity 10, empty ring, statistics zero; the
// store contents are not cleared and need no clearing pass.
// receiver stall: the finished result holds in the output register, one more
// item is still taken and waits in the commit state until the register frees.
module sample_ring_fifo_with_stats (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    srfs_in_if.sink                         i_in,
    srfs_out_if.source                      o_out
);
    import srfs_pkg::*;

    `include "sample_ring_fifo_with_stats_macros.svh"

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    srfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    srfs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_opcode         (i_in.opcode),
        .i_sample_in      (i_in.sample_in),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_ok             (o_out.ok),
        .o_head_sample    (o_out.head_sample),
        .o_queued         (o_out.queued),
        .o_overflow_count (o_out.overflow_count),
        .o_high_water     (o_out.high_water)
    );

    `SRFS_ASSERT_NEXT(a_one_item_in_flight, i_in.valid && in_ready, !in_ready)
    `SRFS_ASSERT_SAME(a_queued_below_peak, o_out.valid, o_out.queued <= o_out.high_water)
    `SRFS_ASSERT_SAME(a_head_zero_on_fail, o_out.valid && !o_out.ok, o_out.head_sample == '0)

endmodule

// ===== design/srfs_ctrl.sv =====
module srfs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  srfs_pkg::t_dp_status i_status,
    output srfs_pkg::t_dp_cmd    o_cmd
);
    import srfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready  = i_rst_n;
                o_cmd.start = i_in_valid && i_rst_n;
            end
            S_EXEC: begin
                // commit only when the output register can take the result
                o_cmd.exec = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/srfs_datapath.sv =====
module srfs_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  srfs_pkg::t_dp_cmd               i_cmd,
    output srfs_pkg::t_dp_status            o_status,
    input  logic [srfs_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [srfs_pkg::SAMPLE_IN_W-1:0] i_sample_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_ok,
    output logic [srfs_pkg::HEAD_W-1:0]     o_head_sample,
    output logic [srfs_pkg::QUEUED_W-1:0]   o_queued,
    output logic [srfs_pkg::OVF_W-1:0]      o_overflow_count,
    output logic [srfs_pkg::HWM_W-1:0]      o_high_water
);
    import srfs_pkg::*;

    logic [SAMPLE_WIDTH-1:0] r_store [STORE_DEPTH];

    logic                   r_enabled;
    logic [SIZE_LOG2_W-1:0] r_size_log2;
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [OVF_W-1:0]       r_dropped;
    logic [PTR_W-1:0]       r_peak;
    logic                   r_out_valid;

    t_opcode                 r_op;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [SAMPLE_WIDTH-1:0] r_rd_data;

    logic                   r_ok;
    logic [HEAD_W-1:0]      r_head;
    logic [QUEUED_W-1:0]    r_queued;

    logic [PTR_W-1:0]  cap;
    logic [ADDR_W-1:0] cap_mask;
    logic [PTR_W-1:0]  used;
    logic              is_full;
    logic              is_empty;
    logic              do_push;
    logic              do_drop;
    logic              do_peek;
    logic              do_consume;
    logic [PTR_W-1:0]  n_used;

    always_comb begin
        if (int'(r_size_log2) >= CAP_MAX_LOG2) begin
            cap = PTR_W'(1) << CAP_MAX_LOG2;
        end else begin
            cap = PTR_W'(1) << r_size_log2;
        end
    end

    assign cap_mask = ADDR_W'(cap - PTR_W'(1));
    assign used     = r_wr_ptr - r_rd_ptr;
    assign is_full  = (used >= cap);
    assign is_empty = (used == '0);

    always_comb begin
        do_push    = 1'b0;
        do_drop    = 1'b0;
        do_peek    = 1'b0;
        do_consume = 1'b0;
        if (r_enabled) begin
            case (r_op)
                OP_PUSH: begin
                    do_push = !is_full;
                    do_drop = is_full;
                end
                OP_PEEK:    do_peek    = !is_empty;
                OP_CONSUME: do_consume = !is_empty;
                default: begin
                    do_push = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_used = used;
        if (do_push) begin
            n_used = used + PTR_W'(1);
        end else if (do_consume) begin
            n_used = used - PTR_W'(1);
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // sample store: read at accept, written at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_data <= r_store[r_rd_ptr[ADDR_W-1:0] & cap_mask];
        end
        if (i_cmd.exec && do_push) begin
            r_store[r_wr_ptr[ADDR_W-1:0] & cap_mask] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= t_opcode'(i_opcode);
            r_sample <= SAMPLE_WIDTH'(i_sample_in);
        end
        if (i_cmd.exec) begin
            r_ok     <= do_push || do_peek || do_consume;
            r_head   <= do_peek ? HEAD_W'(r_rd_data) : '0;
            r_queued <= QUEUED_W'(n_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_size_log2 <= SIZE_LOG2_RESET;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_dropped   <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                // any register write re-attaches the ring
                case (i_cfg_idx)
                    CFG_RING_ENABLED:   r_enabled   <= i_cfg_wdata[0];
                    CFG_RING_SIZE_LOG2: r_size_log2 <= SIZE_LOG2_W'(i_cfg_wdata);
                    default:            r_enabled   <= r_enabled;
                endcase
                r_wr_ptr  <= '0;
                r_rd_ptr  <= '0;
                r_dropped <= '0;
                r_peak    <= '0;
            end else if (i_cmd.exec) begin
                if (do_push) begin
                    r_wr_ptr <= r_wr_ptr + PTR_W'(1);
                    if (n_used > r_peak) begin
                        r_peak <= n_used;
                    end
                end
                if (do_consume) begin
                    r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                end
                if (do_drop && (r_dropped != '1)) begin
                    r_dropped <= r_dropped + OVF_W'(1);
                end
            end
        end
    end

    // counters are latched together with the rest of the result
    logic [OVF_W-1:0] r_ovf_out;
    logic [HWM_W-1:0] r_hwm_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ovf_out <= (do_drop && (r_dropped != '1)) ? r_dropped + OVF_W'(1) : r_dropped;
            r_hwm_out <= (do_push && (n_used > r_peak)) ? HWM_W'(n_used) : HWM_W'(r_peak);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_ok;
    assign o_head_sample    = r_head;
    assign o_queued         = r_queued;
    assign o_overflow_count = r_ovf_out;
    assign o_high_water     = r_hwm_out;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import srfs_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [OPCODE_W-1:0]    op;
        logic [SAMPLE_IN_W-1:0] sample;
    } t_ring_op;

    typedef struct packed {
        logic                ok;
        logic [HEAD_W-1:0]   head;
        logic [QUEUED_W-1:0] queued;
        logic [OVF_W-1:0]    ovf;
        logic [HWM_W-1:0]    hwm;
    } t_ring_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    srfs_in_if  in_if ();
    srfs_out_if out_if ();

    sample_ring_fifo_with_stats u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // ring state as seen by the checker
    logic [SAMPLE_WIDTH-1:0] ring_store [STORE_DEPTH];
    int unsigned             wr_ptr;
    int unsigned             rd_ptr;
    logic [OVF_W-1:0]        drop_cnt;
    int unsigned             peak_fill;
    logic                    ring_on;
    logic [SIZE_LOG2_W-1:0]  size_log2;

    t_ring_op     op_pending_q [$];
    t_ring_result result_due_q [$];
    t_ring_op     drv_item;
    t_ring_result got_result;
    t_ring_result due_result;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int quiet_cycles;
    int n_errors;
    int n_accepted;
    int n_results;
    int n_refused_pushes;
    int n_empty_misses;
    int top_fill;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_capacity();
        if (size_log2 > CAP_MAX_LOG2)
            return 1 << CAP_MAX_LOG2;
        return 1 << size_log2;
    endfunction

    function automatic t_ring_result ring_apply_op(logic [OPCODE_W-1:0] op,
                                                   logic [SAMPLE_IN_W-1:0] smp);
        t_ring_result r;
        int unsigned  cap;
        int unsigned  used;
        r = '0;
        cap = ring_capacity();
        used = wr_ptr - rd_ptr;
        if (ring_on) begin
            case (op)
                OP_PUSH: begin
                    if (used >= cap) begin
                        n_refused_pushes++;
                        if (drop_cnt != '1)
                            drop_cnt++;
                    end else begin
                        ring_store[wr_ptr & (cap - 1)] = smp;
                        wr_ptr++;
                        used++;
                        if (used > peak_fill)
                            peak_fill = used;
                        r.ok = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (used != 0) begin
                        r.head = ring_store[rd_ptr & (cap - 1)];
                        r.ok = 1'b1;
                    end else begin
                        n_empty_misses++;
                    end
                end
                OP_CONSUME: begin
                    if (used != 0) begin
                        rd_ptr++;
                        used--;
                        r.ok = 1'b1;
                    end else begin
                        n_empty_misses++;
                    end
                end
                default: ;
            endcase
        end
        if (used > cap)
            used = cap;
        if (used > top_fill)
            top_fill = used;
        r.queued = used[QUEUED_W-1:0];
        r.ovf = drop_cnt;
        r.hwm = peak_fill[HWM_W-1:0];
        return r;
    endfunction

    // input side: one transfer per handshake, random idle cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                result_due_q.push_back(ring_apply_op(in_if.opcode, in_if.sample_in));
                n_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (op_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv_item = op_pending_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.opcode <= drv_item.op;
                    in_if.sample_in <= drv_item.sample;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // output side: compare each result with the oldest one due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_result = '{out_if.ok, out_if.head_sample, out_if.queued,
                               out_if.overflow_count, out_if.high_water};
                n_results++;
                if (result_due_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0h",
                             $time, got_result);
                    n_errors++;
                end else begin
                    due_result = result_due_q.pop_front();
                    check_field("ok", 64'(due_result.ok), 64'(got_result.ok));
                    check_field("head_sample", 64'(due_result.head), 64'(got_result.head));
                    check_field("queued", 64'(due_result.queued), 64'(got_result.queued));
                    check_field("overflow_count", 64'(due_result.ovf), 64'(got_result.ovf));
                    check_field("high_water", 64'(due_result.hwm), 64'(got_result.hwm));
                end
            end
            if (hold_reqs != hold_seen) begin
                hold_seen <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("sample_ring_fifo_with_stats regression: fail");
                $finish;
            end
        end
    end

    task automatic queue_op(logic [OPCODE_W-1:0] op, logic [SAMPLE_IN_W-1:0] smp);
        op_pending_q.push_back('{op, smp});
    endtask

    task automatic wait_drained();
        // sample between edges so the driver and monitor updates have settled
        @(negedge i_clk);
        while (op_pending_q.size() != 0 || in_if.valid || result_due_q.size() != 0)
            @(negedge i_clk);
        // let the commit stage settle before touching the registers
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_RING_ENABLED)
            ring_on = data[0];
        else
            size_log2 = data;
        // every write re-attaches the ring, store contents survive
        wr_ptr = 0;
        rd_ptr = 0;
        drop_cnt = '0;
        peak_fill = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return $urandom();
    endfunction

    task automatic queue_mixed(int n);
        int push_wt;
        int r;
        for (int i = 0; i < n; i++) begin
            // bias flips every burst so the ring both fills and drains
            if (i % 16 == 0) begin
                r = $urandom_range(2);
                push_wt = (r == 0) ? 15 : (r == 1) ? 50 : 85;
            end
            if ($urandom_range(99) < 4) begin
                queue_op(OP_UNUSED, pick_sample());
            end else begin
                r = $urandom_range(99);
                if (r < push_wt)
                    queue_op(OP_PUSH, pick_sample());
                else if (r < push_wt + (100 - push_wt) / 3)
                    queue_op(OP_PEEK, pick_sample());
                else
                    queue_op(OP_CONSUME, pick_sample());
            end
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] en_w, logic [CFG_DATA_W-1:0] size_w,
                             int tx_pct, int rx_pct, int fill_n, int n_mixed,
                             bit long_hold, bit mid_pause);
        wait_drained();
        cfg_write(CFG_RING_ENABLED, en_w);
        cfg_write(CFG_RING_SIZE_LOG2, size_w);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < fill_n; i++)
            queue_op((i % 50 == 49) ? OP_PEEK : OP_PUSH, pick_sample());
        if (mid_pause) begin
            queue_mixed(n_mixed / 2);
            wait_drained();
            queue_mixed(n_mixed - n_mixed / 2);
        end else begin
            queue_mixed(n_mixed);
        end
        // sender keeps offering while the receiver is held off
        if (long_hold)
            hold_reqs++;
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.opcode = '0;
        in_if.sample_in = '0;
        out_if.ready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_reqs = 0;
        quiet_cycles = 0;
        n_errors = 0;
        n_accepted = 0;
        n_results = 0;
        n_refused_pushes = 0;
        n_empty_misses = 0;
        top_fill = 0;
        ring_on = 1'b0;
        size_log2 = SIZE_LOG2_RESET;
        wr_ptr = 0;
        rd_ptr = 0;
        drop_cnt = '0;
        peak_fill = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ring detached after reset: everything fails, no overflow counted
        queue_op(OP_PUSH, '1);
        queue_op(OP_PEEK, '0);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_UNUSED, '1);
        wait_drained();

        // single-entry ring: empty misses, full drop, head readback
        cfg_write(CFG_RING_ENABLED, 4'hF);
        cfg_write(CFG_RING_SIZE_LOG2, 4'd0);
        queue_op(OP_PEEK, '0);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_PUSH, 32'h0000_0000);
        queue_op(OP_PUSH, 32'hFFFF_FFFF);
        queue_op(OP_PEEK, '0);
        queue_op(OP_UNUSED, '0);
        queue_op(OP_CONSUME, '1);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_PUSH, 32'hFFFF_FFFF);
        queue_op(OP_PEEK, '0);
        queue_op(OP_PUSH, 32'hA5A5_A5A5);
        wait_drained();

        // oversized log2 saturates at the store depth
        cfg_write(CFG_RING_SIZE_LOG2, 4'd15);
        queue_op(OP_PUSH, 32'h5A5A_5A5A);
        queue_op(OP_PUSH, 32'h8000_0001);
        queue_op(OP_PEEK, '0);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_PEEK, '0);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_CONSUME, '0);
        queue_op(OP_UNUSED, '1);

        run_phase(4'h1, 4'd2, 0, 0, 0, 120, 1'b1, 1'b0);
        run_phase(4'h1, 4'd3, 53, 0, 0, 120, 1'b0, 1'b1);
        run_phase(4'h1, 4'd10, 0, 53, 1050, 30, 1'b0, 1'b0);
        run_phase(4'h1, 4'd0, 33, 33, 0, 100, 1'b0, 1'b0);
        run_phase(4'h1, 4'd5, 53, 53, 0, 100, 1'b0, 1'b0);
        run_phase(4'hE, 4'd12, 33, 33, 0, 40, 1'b0, 1'b0);
        run_phase(4'h3, 4'd1, 0, 0, 0, 100, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d operations and %0d results over capacities 1 to %0d",
                 n_accepted, n_results, STORE_DEPTH);
        $display("refused pushes %0d, empty peeks/consumes %0d, highest occupancy %0d",
                 n_refused_pushes, n_empty_misses, top_fill);
        if (n_errors == 0) begin
            $display("sample_ring_fifo_with_stats regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("sample_ring_fifo_with_stats regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/srfs_pkg.sv
design/srfs_in_if.sv
design/srfs_out_if.sv
design/srfs_ctrl.sv
design/srfs_datapath.sv
design/sample_ring_fifo_with_stats.sv
tb/tb.sv
